FILE: rtl/histogram_smooth_peak_pick_defines.svh
// Assertion macros shared by the divider and the datapath RTL files.
`ifndef HISTOGRAM_SMOOTH_PEAK_PICK_DEFINES_SVH
`define HISTOGRAM_SMOOTH_PEAK_PICK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/hspp_pkg.sv
`timescale 1ns / 1ps

package hspp_pkg;

   localparam int MAX_BINS    = 128;
   localparam int BIN_W       = $clog2(MAX_BINS);
   localparam int CNT_W       = $clog2(MAX_BINS + 2);
   localparam int MAX_PASSES  = 8;
   localparam int PASS_W      = 4;
   localparam int IN_W        = 24;
   localparam int FRAC_W      = 16;
   localparam int VAL_W       = 40;
   localparam int LIM_W       = 56;
   localparam int HALF_W      = 20;
   localparam int THR_W       = 16;
   localparam int ANG_W       = 16;
   localparam int NUM_W       = 24;
   localparam int GEO_W       = 4;
   localparam int MAX_RESULTS = 64;
   localparam int RES_W       = 7;
   localparam int DIV_Q_W     = 17;
   localparam int DIV_CNT_W   = 5;
   localparam int ANGLE_SPAN  = 46080;
   localparam int GEO_TOL     = 896;
   localparam int NUM_KNOWN   = 8;

   typedef logic [ANG_W-1:0] angle_table_type [NUM_KNOWN];
   localparam angle_table_type KNOWN_ANGLE = '{
      16'd15360, 16'd18048, 16'd23040, 16'd28024,
      16'd30720, 16'd34560, 16'd38400, 16'd46080
   };

   typedef enum logic [1:0] {
      CSR_BIN_COUNT,
      CSR_SMOOTH_PASSES,
      CSR_NORMALIZE,
      CSR_THRESHOLD
   } csr_index_type;

   typedef enum logic [1:0] {
      WALK_SMOOTH,
      WALK_MAX,
      WALK_PEAK
   } walk_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SM_INIT,
      ST_SM_WALK,
      ST_MX_INIT,
      ST_MX_WALK,
      ST_LIM_LO,
      ST_LIM_HI,
      ST_PK_INIT,
      ST_PK_WALK,
      ST_ANG_GO,
      ST_ANG_WAIT,
      ST_VAL_GO,
      ST_VAL_WAIT,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic          load;
      logic          walk_clear;
      logic          walk_step;
      walk_mode_type mode;
      logic          lim_lo;
      logic          lim_hi;
      logic          scan_init;
      logic          div_ang;
      logic          div_val;
      logic          cap_ang;
      logic          cap_val;
      logic          emit_pend;
      logic          finish;
   } dp_cmd_type;

   typedef struct packed {
      logic fire;
      logic walk_last;
      logic hit;
      logic div_busy;
   } dp_status_type;

   // First known angle lying closer than the tolerance, zero if none.
   function automatic logic [GEO_W-1:0] geometry_of(input logic [ANG_W-1:0] ang);
      logic [GEO_W-1:0] code;
      logic [ANG_W-1:0] gap;
      code = '0;
      for (int k = NUM_KNOWN - 1; k >= 0; k--) begin
         gap = (ang > KNOWN_ANGLE[k]) ? ang - KNOWN_ANGLE[k] : KNOWN_ANGLE[k] - ang;
         if (gap < ANG_W'(GEO_TOL)) begin
            code = GEO_W'(k + 1);
         end
      end
      return code;
   endfunction

endpackage

FILE: rtl/hspp_divider.sv
`timescale 1ns / 1ps
`include "histogram_smooth_peak_pick_defines.svh"

// Restoring divider, one quotient bit per cycle. The upper part of the
// dividend must be below the divisor so that the quotient fits.
module hspp_divider
   import hspp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VAL_W-1:0]   rem_init,
   input  logic [DIV_Q_W-1:0] low_init,
   input  logic [VAL_W-1:0]   divisor,
   output logic               busy,
   output logic [DIV_Q_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0]     rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   low_ff, low_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic [VAL_W-1:0]     div_ff, div_in;
   logic [VAL_W:0]       trial;
   logic                 ge;

   assign trial = {rem_ff, low_ff[DIV_Q_W-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = rem_init;
         low_in  = low_init;
         q_in    = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? VAL_W'(trial - {1'b0, div_ff}) : trial[VAL_W-1:0];
         low_in = {low_ff[DIV_Q_W-2:0], 1'b0};
         q_in   = {q_ff[DIV_Q_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_Q_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

   `ASSERT_IMPLIES(a_start_when_free, clock, reset, start, !busy_ff)
   `ASSERT_IMPLIES(a_count_bound, clock, reset, busy_ff, cnt_ff < DIV_CNT_W'(DIV_Q_W))

endmodule

FILE: rtl/hspp_datapath.sv
`timescale 1ns / 1ps
`include "histogram_smooth_peak_pick_defines.svh"

module hspp_datapath
   import hspp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd_in,
   output dp_status_type    status_out,
   input  logic [CNT_W-1:0] n_bins,
   input  logic [THR_W-1:0] threshold,
   input  logic             normalize,
   input  logic [IN_W-1:0]  bin_value,
   output logic             rsp_valid,
   output logic             rsp_found,
   output logic [BIN_W-1:0] rsp_peak_bin,
   output logic [ANG_W-1:0] rsp_peak_angle,
   output logic [VAL_W-1:0] rsp_peak_value,
   output logic [GEO_W-1:0] rsp_geometry_code,
   output logic             rsp_last_result
);

   logic [VAL_W-1:0] mem [MAX_BINS];

   logic [CNT_W-1:0] load_index_ff;
   logic [CNT_W-1:0] load_next;
   logic [CNT_W-1:0] walk_cnt_ff;
   logic [CNT_W-1:0] n_plus1;
   logic [CNT_W-1:0] k_idx;
   logic [VAL_W-1:0] a_ff, b_ff, rd_ff, nxt;
   logic [VAL_W-1:0] max_ff;
   logic [LIM_W-1:0] lim_ff;
   logic [HALF_W-1:0] lim_slice;
   logic [THR_W+HALF_W-1:0] lim_part;
   logic [VAL_W+1:0] smooth_sum;
   logic             proc;
   logic             hit;
   logic [RES_W-1:0] peak_cnt_ff;
   logic [VAL_W-1:0] cand_val_ff;
   logic [BIN_W-1:0] cand_idx_ff;
   logic             pend_valid_ff;
   logic [BIN_W-1:0] pend_bin_ff;
   logic [ANG_W-1:0] pend_angle_ff;
   logic [VAL_W-1:0] pend_value_ff;
   logic             emit;
   logic             we;
   logic [BIN_W-1:0] waddr;
   logic [VAL_W-1:0] wdata;
   logic [NUM_W-1:0] ang_num;
   logic             div_start;
   logic [VAL_W-1:0] div_rem;
   logic [DIV_Q_W-1:0] div_low;
   logic [VAL_W-1:0] div_den;
   logic             div_busy;
   logic [DIV_Q_W-1:0] div_q;

   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [BIN_W-1:0] rsp_bin_ff;
   logic [ANG_W-1:0] rsp_angle_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic [GEO_W-1:0] rsp_geo_ff;
   logic             rsp_last_ff;

   assign load_next = load_index_ff + 1'b1;
   assign n_plus1   = n_bins + 1'b1;
   assign k_idx     = walk_cnt_ff - 1'b1;

   // The walk issues a read at count c and consumes the word of bin c-1.
   assign proc = cmd_in.walk_step && (walk_cnt_ff != '0);
   assign nxt  = (k_idx < n_bins) ? rd_ff : '0;

   assign smooth_sum = {2'b00, a_ff} + {1'b0, b_ff, 1'b0} + {2'b00, nxt};

   assign hit = cmd_in.walk_step && (cmd_in.mode == WALK_PEAK)
                && (walk_cnt_ff >= CNT_W'(3)) && (walk_cnt_ff <= n_bins)
                && (b_ff > a_ff) && (b_ff >= nxt)
                && ({b_ff, {FRAC_W{1'b0}}} > lim_ff)
                && (peak_cnt_ff < RES_W'(MAX_RESULTS));

   always_comb begin
      we    = 1'b0;
      waddr = load_index_ff[BIN_W-1:0];
      wdata = {bin_value, {FRAC_W{1'b0}}};
      if (cmd_in.load) begin
         we = 1'b1;
      end else if (proc && (cmd_in.mode == WALK_SMOOTH) && (walk_cnt_ff >= CNT_W'(2))) begin
         we    = 1'b1;
         waddr = BIN_W'(walk_cnt_ff - CNT_W'(2));
         wdata = smooth_sum[VAL_W+1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd_in.walk_step) begin
         rd_ff <= mem[walk_cnt_ff[BIN_W-1:0]];
      end
   end

   assign ang_num   = NUM_W'({cand_idx_ff, 1'b1}) * NUM_W'(ANGLE_SPAN) + NUM_W'(n_bins);
   assign div_start = cmd_in.div_ang || cmd_in.div_val;

   always_comb begin
      if (cmd_in.div_ang) begin
         div_rem = VAL_W'(ang_num >> DIV_Q_W);
         div_low = ang_num[DIV_Q_W-1:0];
         div_den = VAL_W'({n_bins, 1'b0});
      end else begin
         div_rem = cand_val_ff >> 1;
         div_low = {cand_val_ff[0], {FRAC_W{1'b0}}};
         div_den = max_ff;
      end
   end

   hspp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .low_init (div_low),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
      end else if (cmd_in.load) begin
         load_index_ff <= (load_next < n_bins) ? load_next : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_cnt_ff <= '0;
      end else if (cmd_in.walk_clear) begin
         walk_cnt_ff <= '0;
      end else if (cmd_in.walk_step) begin
         walk_cnt_ff <= walk_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_in.walk_clear) begin
         a_ff <= '0;
         b_ff <= '0;
      end else if (proc) begin
         a_ff <= b_ff;
         b_ff <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else if (cmd_in.walk_clear && (cmd_in.mode == WALK_MAX)) begin
         max_ff <= '0;
      end else if (proc && (cmd_in.mode == WALK_MAX) && (nxt > max_ff)) begin
         max_ff <= nxt;
      end
   end

   // The threshold product is built from two narrower partial products.
   assign lim_slice = cmd_in.lim_lo ? max_ff[HALF_W-1:0] : max_ff[VAL_W-1:HALF_W];
   assign lim_part  = (THR_W+HALF_W)'(threshold) * (THR_W+HALF_W)'(lim_slice);

   always_ff @(posedge clock) begin
      if (cmd_in.lim_lo) begin
         lim_ff <= LIM_W'(lim_part);
      end else if (cmd_in.lim_hi) begin
         lim_ff <= lim_ff + {lim_part, {HALF_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_cnt_ff   <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (cmd_in.scan_init) begin
            peak_cnt_ff <= '0;
         end else if (hit) begin
            peak_cnt_ff <= peak_cnt_ff + 1'b1;
         end
         if (cmd_in.scan_init || cmd_in.finish) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd_in.cap_val) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         cand_val_ff <= b_ff;
         cand_idx_ff <= BIN_W'(walk_cnt_ff - CNT_W'(2));
      end
      if (cmd_in.cap_ang) begin
         pend_angle_ff <= div_q[ANG_W-1:0];
      end
      if (cmd_in.cap_val) begin
         pend_bin_ff   <= cand_idx_ff;
         pend_value_ff <= normalize ? VAL_W'(div_q) : cand_val_ff;
      end
   end

   assign emit = (cmd_in.emit_pend && pend_valid_ff) || cmd_in.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
      end
      if (emit) begin
         if (pend_valid_ff) begin
            rsp_found_ff <= 1'b1;
            rsp_bin_ff   <= pend_bin_ff;
            rsp_angle_ff <= pend_angle_ff;
            rsp_value_ff <= pend_value_ff;
            rsp_geo_ff   <= geometry_of(pend_angle_ff);
         end else begin
            rsp_found_ff <= 1'b0;
            rsp_bin_ff   <= '0;
            rsp_angle_ff <= '0;
            rsp_value_ff <= '0;
            rsp_geo_ff   <= '0;
         end
         rsp_last_ff <= cmd_in.finish;
      end
   end

   assign status_out.fire      = cmd_in.load && (load_next >= n_bins);
   assign status_out.walk_last = cmd_in.walk_step && (walk_cnt_ff == n_plus1);
   assign status_out.hit       = hit;
   assign status_out.div_busy  = div_busy;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_peak_bin      = rsp_bin_ff;
   assign rsp_peak_angle    = rsp_angle_ff;
   assign rsp_peak_value    = rsp_value_ff;
   assign rsp_geometry_code = rsp_geo_ff;
   assign rsp_last_result   = rsp_last_ff;

   `ASSERT_IMPLIES(a_walk_in_range, clock, reset, cmd_in.walk_step, walk_cnt_ff <= n_plus1)
   `ASSERT_NEXT(a_quiet_after_last, clock, reset, rsp_valid_ff && rsp_last_ff, !rsp_valid_ff)

endmodule

FILE: rtl/hspp_ctrl.sv
`timescale 1ns / 1ps

module hspp_ctrl
   import hspp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              small_bins,
   input  logic [PASS_W-1:0] passes,
   input  logic              normalize,
   input  dp_status_type     status_in,
   output dp_cmd_type        cmd_out,
   output logic              busy
);

   ctrl_state_type    state_ff, state_in;
   logic [PASS_W-1:0] pass_ff, pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd_out  = '0;
      cmd_out.mode = WALK_SMOOTH;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_out.load = 1'b1;
               if (status_in.fire) begin
                  pass_in  = '0;
                  state_in = (!small_bins && (passes != '0)) ? ST_SM_INIT : ST_MX_INIT;
               end
            end
         end
         ST_SM_INIT: begin
            cmd_out.walk_clear = 1'b1;
            state_in = ST_SM_WALK;
         end
         ST_SM_WALK: begin
            cmd_out.walk_step = 1'b1;
            if (status_in.walk_last) begin
               pass_in  = pass_ff + 1'b1;
               state_in = (pass_in < passes) ? ST_SM_INIT : ST_MX_INIT;
            end
         end
         ST_MX_INIT: begin
            cmd_out.mode       = WALK_MAX;
            cmd_out.walk_clear = 1'b1;
            state_in = ST_MX_WALK;
         end
         ST_MX_WALK: begin
            cmd_out.mode      = WALK_MAX;
            cmd_out.walk_step = 1'b1;
            if (status_in.walk_last) begin
               state_in = ST_LIM_LO;
            end
         end
         ST_LIM_LO: begin
            cmd_out.lim_lo = 1'b1;
            state_in = ST_LIM_HI;
         end
         ST_LIM_HI: begin
            cmd_out.lim_hi = 1'b1;
            state_in = ST_PK_INIT;
         end
         ST_PK_INIT: begin
            cmd_out.mode       = WALK_PEAK;
            cmd_out.walk_clear = 1'b1;
            cmd_out.scan_init  = 1'b1;
            state_in = ST_PK_WALK;
         end
         ST_PK_WALK: begin
            cmd_out.mode      = WALK_PEAK;
            cmd_out.walk_step = 1'b1;
            if (status_in.hit) begin
               state_in = ST_ANG_GO;
            end else if (status_in.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_ANG_GO: begin
            // The previous peak is known not to be the last one now.
            cmd_out.mode      = WALK_PEAK;
            cmd_out.div_ang   = 1'b1;
            cmd_out.emit_pend = 1'b1;
            state_in = ST_ANG_WAIT;
         end
         ST_ANG_WAIT: begin
            cmd_out.mode = WALK_PEAK;
            if (!status_in.div_busy) begin
               cmd_out.cap_ang = 1'b1;
               if (normalize) begin
                  state_in = ST_VAL_GO;
               end else begin
                  cmd_out.cap_val = 1'b1;
                  state_in = ST_PK_WALK;
               end
            end
         end
         ST_VAL_GO: begin
            cmd_out.mode    = WALK_PEAK;
            cmd_out.div_val = 1'b1;
            state_in = ST_VAL_WAIT;
         end
         ST_VAL_WAIT: begin
            cmd_out.mode = WALK_PEAK;
            if (!status_in.div_busy) begin
               cmd_out.cap_val = 1'b1;
               state_in = ST_PK_WALK;
            end
         end
         ST_FINISH: begin
            cmd_out.mode   = WALK_PEAK;
            cmd_out.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/histogram_smooth_peak_pick.sv
`timescale 1ns / 1ps

// Histogram smoothing and peak picker.
// Bin counts arrive one per transfer on req_bin_value, in bin order; a transfer
// happens at a clock edge with start high and busy low. While bins load, busy
// stays low and a bin may be sent every cycle. The transfer of the last bin
// starts a burst: each smoothing pass, then the maximum search and then the
// peak scan walk the bin memory, with setup states between. Each peak found
// pauses the scan while the bit-serial divider computes its angle and, with
// normalization, its value. Results leave on the rsp_ ports, each for one cycle
// marked by rsp_valid; rsp_last_result marks the final one. The receiver cannot
// stall, and none is needed. A histogram without peaks yields one result with
// rsp_found low. Configuration is written through csr_ while the block is idle;
// the user must keep to this, since the block does not enforce it. A synchronous
// reset returns to idle, clears the load position and restores the register
// defaults; the bin memory is not cleared, since it is written before read.
module histogram_smooth_peak_pick
   import hspp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [IN_W-1:0]  req_bin_value,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [THR_W-1:0] csr_write_data,
   output logic             rsp_valid,
   output logic             rsp_found,
   output logic [BIN_W-1:0] rsp_peak_bin,
   output logic [ANG_W-1:0] rsp_peak_angle,
   output logic [VAL_W-1:0] rsp_peak_value,
   output logic [GEO_W-1:0] rsp_geometry_code,
   output logic             rsp_last_result
);

   logic [7:0]        bin_count_ff;
   logic [PASS_W-1:0] passes_ff;
   logic              normalize_ff;
   logic [THR_W-1:0]  threshold_ff;
   logic [CNT_W-1:0]  n_eff;
   logic [PASS_W-1:0] passes_eff;
   logic              ctrl_busy;
   dp_cmd_type        cmd;
   dp_status_type     status;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= 8'd90;
         passes_ff    <= 4'd1;
         normalize_ff <= 1'b1;
         threshold_ff <= 16'd5243;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIN_COUNT:     bin_count_ff <= csr_write_data[7:0];
            CSR_SMOOTH_PASSES: passes_ff    <= csr_write_data[PASS_W-1:0];
            CSR_NORMALIZE:     normalize_ff <= csr_write_data[0];
            CSR_THRESHOLD:     threshold_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // A count of zero acts as one bin; counts and passes saturate.
   always_comb begin
      if (bin_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (CNT_W'(bin_count_ff) > CNT_W'(MAX_BINS)) begin
         n_eff = CNT_W'(MAX_BINS);
      end else begin
         n_eff = CNT_W'(bin_count_ff);
      end
      passes_eff = (passes_ff > PASS_W'(MAX_PASSES)) ? PASS_W'(MAX_PASSES) : passes_ff;
   end

   hspp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start && !ctrl_busy),
      .small_bins (n_eff < CNT_W'(3)),
      .passes     (passes_eff),
      .normalize  (normalize_ff),
      .status_in  (status),
      .cmd_out    (cmd),
      .busy       (ctrl_busy)
   );

   hspp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd_in            (cmd),
      .status_out        (status),
      .n_bins            (n_eff),
      .threshold         (threshold_ff),
      .normalize         (normalize_ff),
      .bin_value         (req_bin_value),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_peak_bin      (rsp_peak_bin),
      .rsp_peak_angle    (rsp_peak_angle),
      .rsp_peak_value    (rsp_peak_value),
      .rsp_geometry_code (rsp_geometry_code),
      .rsp_last_result   (rsp_last_result)
   );

   assign busy = ctrl_busy;

endmodule
